// File: src/nnts_pkg.sv
// Package for the nearest-neighbor thumbnail scaler: size limits, derived widths,
// register indexes, the shared geometry and result types, and the dimension clamp.
// Has no dependencies; every other file of the block imports it.
package nnts_pkg;

   // Size limits of the scaler.
   localparam int MAX_THUMB_DIM  = 256;
   localparam int MAX_SOURCE_DIM = 4096;

   // Fixed widths of the configuration registers and result fields.
   localparam int CFG_W       = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int PIXEL_W     = 32;
   localparam int COORD_OUT_W = 8;
   localparam int SIZE_OUT_W  = 9;

   // Widths that follow from the size limits.
   localparam int SRC_W   = $clog2(MAX_SOURCE_DIM + 1);  // a clamped source side
   localparam int POS_W   = $clog2(MAX_SOURCE_DIM);      // a position inside the frame
   localparam int THUMB_W = $clog2(MAX_THUMB_DIM + 1);   // a thumbnail side
   localparam int NUM_W   = SRC_W + THUMB_W;             // short side times MAX_THUMB_DIM

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = CSR_IDX_W'(1);

   // Thumbnail size and per-axis sampling steps, worked out once per configuration.
   typedef struct packed {
      logic [THUMB_W-1:0] tw;
      logic [THUMB_W-1:0] th;
      logic [SRC_W-1:0]   step_x_q;
      logic [THUMB_W-1:0] step_x_r;
      logic [SRC_W-1:0]   step_y_q;
      logic [THUMB_W-1:0] step_y_r;
   } nnts_geom_type;

   // One thumbnail pixel as it leaves the block.
   typedef struct packed {
      logic [PIXEL_W-1:0]     pixel;
      logic [COORD_OUT_W-1:0] x;
      logic [COORD_OUT_W-1:0] y;
      logic [SIZE_OUT_W-1:0]  width;
      logic [SIZE_OUT_W-1:0]  height;
      logic                   last;
   } nnts_result_type;

   // Register values above the source limit are treated as the limit.
   function automatic logic [SRC_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W+SRC_W-1:0] ext;
      ext = (CFG_W + SRC_W)'(v);
      if (ext > (CFG_W + SRC_W)'(MAX_SOURCE_DIM)) begin
         return SRC_W'(MAX_SOURCE_DIM);
      end
      return SRC_W'(v);
   endfunction

endpackage

// File: src/nnts_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nnts_pkg for the default operand widths.
module nnts_div
   import nnts_pkg::*;
#(
   parameter int DIVIDEND_W = NUM_W,
   parameter int DIVISOR_W  = SRC_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Bring down the next dividend bit and subtract the divisor if it fits.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : DIVISOR_W'(trial);
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_when_finished: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cnt_ff == '0))
      else $error("divider reports done while still iterating");

endmodule

// File: src/nnts_setup.sv
// Setup sequencer: after a register write it works out the thumbnail size and the
// per-axis sampling steps with three passes through one shared divider.
// Depends on nnts_pkg and nnts_div.
module nnts_setup
   import nnts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic [SRC_W-1:0]   src_w,
   input  logic [SRC_W-1:0]   src_h,
   output nnts_geom_type      geom,
   output logic               busy
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SIZE   = 2'd1;
   localparam logic [1:0] ST_STEP_X = 2'd2;
   localparam logic [1:0] ST_STEP_Y = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic               launch_ff, launch_in;
   nnts_geom_type      geom_ff, geom_in;

   logic               over;
   logic               wide;
   logic [SRC_W-1:0]   long_side;
   logic [SRC_W-1:0]   short_side;
   logic [NUM_W-1:0]   div_dividend;
   logic [SRC_W-1:0]   div_divisor;
   logic               div_done;
   logic [NUM_W-1:0]   div_quotient;
   logic [SRC_W-1:0]   div_remainder;
   logic [THUMB_W-1:0] short_thumb;

   // The longer side (width on a tie) is pinned to the maximum when either side is too big.
   assign over = (NUM_W'(src_w) > NUM_W'(MAX_THUMB_DIM)) ||
                 (NUM_W'(src_h) > NUM_W'(MAX_THUMB_DIM));
   assign wide       = src_w >= src_h;
   assign long_side  = wide ? src_w : src_h;
   assign short_side = wide ? src_h : src_w;

   always_comb begin
      unique case (state_ff)
         ST_STEP_X: begin
            div_dividend = NUM_W'(src_w);
            div_divisor  = SRC_W'(geom_ff.tw);
         end
         ST_STEP_Y: begin
            div_dividend = NUM_W'(src_h);
            div_divisor  = SRC_W'(geom_ff.th);
         end
         default: begin
            div_dividend = NUM_W'(short_side) * NUM_W'(MAX_THUMB_DIM);
            div_divisor  = long_side;
         end
      endcase
   end

   nnts_div #(
      .DIVIDEND_W (NUM_W),
      .DIVISOR_W  (SRC_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (launch_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // The scaled short side never drops below one pixel.
   assign short_thumb = (div_quotient[THUMB_W-1:0] == '0) ? THUMB_W'(1)
                                                          : div_quotient[THUMB_W-1:0];

   always_comb begin
      state_in  = state_ff;
      launch_in = 1'b0;
      geom_in   = geom_ff;
      if (restart) begin
         state_in  = ST_SIZE;
         launch_in = 1'b1;
      end else if (div_done && !launch_ff) begin
         unique case (state_ff)
            ST_SIZE: begin
               if (!over) begin
                  geom_in.tw = THUMB_W'(src_w);
                  geom_in.th = THUMB_W'(src_h);
               end else if (wide) begin
                  geom_in.tw = THUMB_W'(MAX_THUMB_DIM);
                  geom_in.th = short_thumb;
               end else begin
                  geom_in.tw = short_thumb;
                  geom_in.th = THUMB_W'(MAX_THUMB_DIM);
               end
               state_in  = ST_STEP_X;
               launch_in = 1'b1;
            end
            ST_STEP_X: begin
               geom_in.step_x_q = SRC_W'(div_quotient);
               geom_in.step_x_r = THUMB_W'(div_remainder);
               state_in  = ST_STEP_Y;
               launch_in = 1'b1;
            end
            ST_STEP_Y: begin
               geom_in.step_y_q = SRC_W'(div_quotient);
               geom_in.step_y_r = THUMB_W'(div_remainder);
               state_in  = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
         geom_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         geom_ff   <= geom_in;
      end
   end

   assign geom = geom_ff;
   assign busy = state_ff != ST_IDLE;

   a_launch_while_busy: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> (state_ff != ST_IDLE))
      else $error("divider launched with the sequencer idle");

endmodule

// File: src/nnts_sampler.sv
// Per-pixel sampler: frame position counters, per-axis target and remainder
// accumulators, and a result register with a skid entry on the output side.
// Depends on nnts_pkg.
module nnts_sampler
   import nnts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic               busy,
   input  logic [SRC_W-1:0]   src_w,
   input  logic [SRC_W-1:0]   src_h,
   input  nnts_geom_type      geom,
   input  logic               req_valid,
   input  logic [PIXEL_W-1:0] req_pixel,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nnts_result_type    rsp_result
);

   logic [POS_W-1:0]   src_col_ff, src_col_in;
   logic [POS_W-1:0]   src_row_ff, src_row_in;
   logic [THUMB_W-1:0] dst_col_ff, dst_col_in;
   logic [THUMB_W-1:0] dst_row_ff, dst_row_in;
   logic [SRC_W-1:0]   col_target_ff, col_target_in;
   logic [THUMB_W-1:0] col_rem_ff, col_rem_in;
   logic [SRC_W-1:0]   row_target_ff, row_target_in;
   logic [THUMB_W-1:0] row_rem_ff, row_rem_in;

   nnts_result_type    main_ff, main_in;
   logic               main_valid_ff, main_valid_in;
   nnts_result_type    skid_ff, skid_in;
   logic               skid_valid_ff, skid_valid_in;

   logic               accept;
   logic               frame_on;
   logic               row_hit;
   logic               col_hit;
   logic               pick;
   logic               take;
   logic               col_last;
   logic               row_last;
   nnts_result_type    result;
   logic [THUMB_W:0]   col_sum;
   logic               col_carry;
   logic [THUMB_W-1:0] col_rem_adv;
   logic [SRC_W-1:0]   col_target_adv;
   logic [THUMB_W:0]   row_sum;
   logic               row_carry;
   logic [THUMB_W-1:0] row_rem_adv;
   logic [SRC_W-1:0]   row_target_adv;

   assign req_stall = busy || restart || skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign frame_on  = (src_w != '0) && (src_h != '0);

   assign row_hit = (dst_row_ff < geom.th) && (SRC_W'(src_row_ff) == row_target_ff);
   assign col_hit = (dst_col_ff < geom.tw) && (SRC_W'(src_col_ff) == col_target_ff);
   assign pick    = accept && frame_on && row_hit && col_hit;

   assign col_last = (SRC_W'(src_col_ff) + 1'b1) >= src_w;
   assign row_last = (SRC_W'(src_row_ff) + 1'b1) >= src_h;

   // Next sample on each axis: target grows by the quotient, plus one on remainder carry.
   assign col_sum        = {1'b0, col_rem_ff} + {1'b0, geom.step_x_r};
   assign col_carry      = col_sum >= {1'b0, geom.tw};
   assign col_rem_adv    = col_carry ? THUMB_W'(col_sum - {1'b0, geom.tw}) : THUMB_W'(col_sum);
   assign col_target_adv = col_target_ff + geom.step_x_q + SRC_W'(col_carry);

   assign row_sum        = {1'b0, row_rem_ff} + {1'b0, geom.step_y_r};
   assign row_carry      = row_sum >= {1'b0, geom.th};
   assign row_rem_adv    = row_carry ? THUMB_W'(row_sum - {1'b0, geom.th}) : THUMB_W'(row_sum);
   assign row_target_adv = row_target_ff + geom.step_y_q + SRC_W'(row_carry);

   always_comb begin
      result.pixel  = req_pixel;
      result.x      = COORD_OUT_W'(dst_col_ff);
      result.y      = COORD_OUT_W'(dst_row_ff);
      result.width  = SIZE_OUT_W'(geom.tw);
      result.height = SIZE_OUT_W'(geom.th);
      result.last   = (({1'b0, dst_col_ff} + 1'b1) == {1'b0, geom.tw}) &&
                      (({1'b0, dst_row_ff} + 1'b1) == {1'b0, geom.th});
   end

   always_comb begin
      src_col_in    = src_col_ff;
      src_row_in    = src_row_ff;
      dst_col_in    = dst_col_ff;
      dst_row_in    = dst_row_ff;
      col_target_in = col_target_ff;
      col_rem_in    = col_rem_ff;
      row_target_in = row_target_ff;
      row_rem_in    = row_rem_ff;
      if (restart) begin
         src_col_in    = '0;
         src_row_in    = '0;
         dst_col_in    = '0;
         dst_row_in    = '0;
         col_target_in = '0;
         col_rem_in    = '0;
         row_target_in = '0;
         row_rem_in    = '0;
      end else if (accept && frame_on) begin
         if (col_hit) begin
            dst_col_in    = dst_col_ff + 1'b1;
            col_target_in = col_target_adv;
            col_rem_in    = col_rem_adv;
         end
         if (col_last) begin
            src_col_in    = '0;
            dst_col_in    = '0;
            col_target_in = '0;
            col_rem_in    = '0;
            if (row_hit) begin
               dst_row_in    = dst_row_ff + 1'b1;
               row_target_in = row_target_adv;
               row_rem_in    = row_rem_adv;
            end
            if (row_last) begin
               src_row_in    = '0;
               dst_row_in    = '0;
               row_target_in = '0;
               row_rem_in    = '0;
            end else begin
               src_row_in = src_row_ff + 1'b1;
            end
         end else begin
            src_col_in = src_col_ff + 1'b1;
         end
      end
   end

   // Result register with one skid entry, so rsp_stall reaches req_stall only through a register.
   assign take = main_valid_ff && !rsp_stall;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = result;
            main_valid_in = pick;
         end
      end else if (pick) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         dst_col_ff    <= '0;
         dst_row_ff    <= '0;
         col_target_ff <= '0;
         col_rem_ff    <= '0;
         row_target_ff <= '0;
         row_rem_ff    <= '0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         src_col_ff    <= src_col_in;
         src_row_ff    <= src_row_in;
         dst_col_ff    <= dst_col_in;
         dst_row_ff    <= dst_row_in;
         col_target_ff <= col_target_in;
         col_rem_ff    <= col_rem_in;
         row_target_ff <= row_target_in;
         row_rem_ff    <= row_rem_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid  = main_valid_ff;
   assign rsp_result = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a result while the result register is empty");

   a_column_in_frame: assert property (@(posedge clock) disable iff (reset)
      (src_w != '0) |-> (SRC_W'(src_col_ff) < src_w))
      else $error("source column ran past the frame width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      (src_h != '0) |-> (SRC_W'(src_row_ff) < src_h))
      else $error("source row ran past the frame height");

endmodule

// File: src/nearest_neighbour_thumbnail_scaler_top.sv
// Top level of the nearest-neighbor thumbnail scaler: configuration registers,
// setup sequencer and per-pixel sampler. Depends on nnts_pkg, nnts_setup, nnts_sampler.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_pixel_rgba
//   rsp_      out        rsp_valid / rsp_stall  rsp_thumb_pixel, rsp_thumb_x, rsp_thumb_y,
//                                               rsp_thumb_width, rsp_thumb_height,
//                                               rsp_frame_last
//   csr_      in         csr_we                 csr_index, csr_data
//
// One source pixel is taken per cycle while req_stall is low. The per-pixel work is a compare of the frame
// position against the column and row targets plus one accumulator update per axis,
// all between the accepted transfer and the result register.
// A register write restarts the frame and starts the setup sequencer, which runs the
// shared bit-serial divider three times (thumbnail size, column step, row step), and
// req_stall stays high from the write cycle until the setup sequencer is idle again.
// Reset is synchronous and active high; it clears both registers, so no pixel yields a
// result until both sides have been written with nonzero values.
// The result register has a skid entry behind it: a pixel is still taken in the cycle
// a result meets rsp_stall, and the output side raises req_stall only once that skid entry is occupied.
module nearest_neighbour_thumbnail_scaler_top
   import nnts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel_rgba,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_thumb_pixel,
   output logic [COORD_OUT_W-1:0] rsp_thumb_x,
   output logic [COORD_OUT_W-1:0] rsp_thumb_y,
   output logic [SIZE_OUT_W-1:0]  rsp_thumb_width,
   output logic [SIZE_OUT_W-1:0]  rsp_thumb_height,
   output logic                   rsp_frame_last,

   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             restart;
   logic [SRC_W-1:0] src_w;
   logic [SRC_W-1:0] src_h;
   nnts_geom_type    geom;
   logic             busy;
   nnts_result_type  result;

   // A write to either register restarts the frame; other indexes are ignored.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH: begin
               width_in = csr_data;
               restart  = 1'b1;
            end
            REG_SOURCE_HEIGHT: begin
               height_in = csr_data;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Oversized register values are used as the source limit.
   assign src_w = clamp_dim(width_ff);
   assign src_h = clamp_dim(height_ff);

   nnts_setup u_setup (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .src_w   (src_w),
      .src_h   (src_h),
      .geom    (geom),
      .busy    (busy)
   );

   nnts_sampler u_sampler (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .busy       (busy),
      .src_w      (src_w),
      .src_h      (src_h),
      .geom       (geom),
      .req_valid  (req_valid),
      .req_pixel  (req_pixel_rgba),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (result)
   );

   assign rsp_thumb_pixel  = result.pixel;
   assign rsp_thumb_x      = result.x;
   assign rsp_thumb_y      = result.y;
   assign rsp_thumb_width  = result.width;
   assign rsp_thumb_height = result.height;
   assign rsp_frame_last   = result.last;

endmodule
